@@ rtl/hpt2d_pkg.sv @@
// shared constants and types for the homogeneous 2d point transform
// no dependencies; imported by homogeneous_point_transform_2d
package hpt2d_pkg;

   localparam int COORD_WIDTH_DEF = 20;
   localparam int FRAC_BITS_DEF   = 8;

   // every matrix row register is this wide, whatever the coordinate width
   localparam int REG_WIDTH       = 60;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MATRIX_ROW0 = 2'd0,
      CSR_MATRIX_ROW1 = 2'd1,
      CSR_MATRIX_ROW2 = 2'd2
   } csr_index_type;

endpackage

@@ rtl/homogeneous_point_transform_2d.sv @@
// Homogeneous 2d point transform: (x, y, 1) times a 3x3 matrix, then X/W and Y/W.
// Throughput: one request per cycle while the output is not stalled; the divider resolves one quotient bit per stage.
// Each stage holds only while it and everything after it are full and the output is stalled.
// Reset (synchronous): clears all valid bits, loads the identity matrix.
// Depends on hpt2d_pkg.
module homogeneous_point_transform_2d #(
   parameter int COORD_WIDTH = hpt2d_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = hpt2d_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [COORD_WIDTH-1:0]            req_point_x,
   input  logic signed [COORD_WIDTH-1:0]            req_point_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_y,
   output logic                                     rsp_w_zero,
   output logic                                     rsp_saturated,
   input  logic                                     csr_write_en,
   input  logic [hpt2d_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [hpt2d_pkg::REG_WIDTH-1:0]          csr_wdata
);
   import hpt2d_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int FB     = FRAC_BITS;
   localparam int PROD_W = 2 * CW;
   localparam int SHC_W  = CW + FB;
   localparam int SUM_W  = ((PROD_W > SHC_W) ? PROD_W : SHC_W) + 2;
   localparam int MAG_W  = SUM_W;
   localparam int NUM_W  = MAG_W + FB;
   localparam int REM_W  = MAG_W + CW;
   localparam int CMP_W  = MAG_W + CW + FB;
   localparam int PAD_W  = (3 * CW > REG_WIDTH) ? 3 * CW : REG_WIDTH;
   localparam int NSTG   = CW + 5;
   localparam int LAST   = NSTG - 1;
   localparam int DIV0   = 3;

   localparam logic [PAD_W-1:0] ONE_PAD = PAD_W'(1) << FB;
   localparam logic [CW-1:0]    SAT_POS = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]    SAT_NEG = {1'b1, {(CW-1){1'b0}}};

   // matrix registers
   logic [REG_WIDTH-1:0]   row_ff [0:2];
   logic [PAD_W-1:0]       row_pad [0:2];
   logic signed [CW-1:0]   m [0:2][0:2];

   // handshake
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] v_in;
   logic [NSTG-1:0] move;

   // stage 0: products; stage 1: column sums; stage 2: magnitudes
   logic signed [PROD_W-1:0] s0_px_ff [0:2];
   logic signed [PROD_W-1:0] s0_py_ff [0:2];
   logic signed [CW-1:0]     s0_c_ff  [0:2];
   logic signed [PROD_W-1:0] s0_px_in [0:2];
   logic signed [PROD_W-1:0] s0_py_in [0:2];
   logic signed [SUM_W-1:0]  s1_sum_ff [0:2];
   logic signed [SUM_W-1:0]  s1_sum_in [0:2];
   logic [MAG_W-1:0]         s2_mag_ff [0:2];
   logic [MAG_W-1:0]         s2_mag_in [0:2];
   logic [2:0]               s2_sgn_ff;
   logic                     s2_wz_ff;

   // divider stages, index 0 is the overflow check, index k has k quotient bits
   logic [REM_W-1:0] d_rem_ff [0:CW][0:1];
   logic [REM_W-1:0] d_rem_in [0:CW][0:1];
   logic [CW-1:0]    d_q_ff   [0:CW][0:1];
   logic [CW-1:0]    d_q_in   [0:CW][0:1];
   logic [1:0]       d_ovf_ff [0:CW];
   logic [1:0]       d_ovf_in [0:CW];
   logic [1:0]       d_neg_ff [0:CW];
   logic [1:0]       d_neg_in [0:CW];
   logic             d_wz_ff  [0:CW];
   logic             d_wz_in  [0:CW];
   logic [MAG_W-1:0] d_den_ff [0:CW];
   logic [MAG_W-1:0] d_den_in [0:CW];

   // output register
   logic signed [CW-1:0] out_ff [0:1];
   logic signed [CW-1:0] out_in [0:1];
   logic                 wz_ff;
   logic                 sat_ff;
   logic                 sat_in;

   // matrix entries, bits past the register read as zero
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_pad[r] = PAD_W'(row_ff[r]);
         for (int c = 0; c < 3; c++) begin
            m[r][c] = row_pad[r][c*CW +: CW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            row_ff[r] <= REG_WIDTH'(ONE_PAD << (r * CW));
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MATRIX_ROW0: row_ff[0] <= csr_wdata;
            CSR_MATRIX_ROW1: row_ff[1] <= csr_wdata;
            CSR_MATRIX_ROW2: row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage moves when there is a bubble at or after it, or the output drains
   always_comb begin
      for (int i = 0; i < NSTG; i++) begin
         move[i] = !rsp_stall || (|(~v_ff >> i));
         v_in[i] = (i == 0) ? req_valid : v_ff[(i == 0) ? 0 : i - 1];
      end
   end

   assign req_stall = !move[0];
   assign rsp_valid = v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (move[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // stages 0 to 2
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s0_px_in[c]  = req_point_x * m[0][c];
         s0_py_in[c]  = req_point_y * m[1][c];
         s1_sum_in[c] = SUM_W'(s0_px_ff[c]) + SUM_W'(s0_py_ff[c])
                      + (SUM_W'(s0_c_ff[c]) <<< FB);
         s2_mag_in[c] = s1_sum_ff[c][SUM_W-1] ? MAG_W'(-s1_sum_ff[c]) : MAG_W'(s1_sum_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         for (int c = 0; c < 3; c++) begin
            s0_px_ff[c] <= s0_px_in[c];
            s0_py_ff[c] <= s0_py_in[c];
            s0_c_ff[c]  <= m[2][c];
         end
      end
      if (move[1]) begin
         for (int c = 0; c < 3; c++) begin
            s1_sum_ff[c] <= s1_sum_in[c];
         end
      end
      if (move[2]) begin
         for (int c = 0; c < 3; c++) begin
            s2_mag_ff[c] <= s2_mag_in[c];
            s2_sgn_ff[c] <= s1_sum_ff[c][SUM_W-1];
         end
         s2_wz_ff <= (s1_sum_ff[2] == '0);
      end
   end

   // restoring divider, quotient limited to CW bits after the overflow check
   always_comb begin
      logic [NUM_W-1:0] num;
      logic [REM_W-1:0] dsh;
      for (int c = 0; c < 2; c++) begin
         num             = NUM_W'(s2_mag_ff[c]) << FB;
         d_ovf_in[0][c]  = CMP_W'(num) >= (CMP_W'(s2_mag_ff[2]) << CW);
         d_rem_in[0][c]  = REM_W'(num);
         d_q_in[0][c]    = '0;
         d_neg_in[0][c]  = s2_sgn_ff[c] ^ s2_sgn_ff[2];
      end
      d_wz_in[0]  = s2_wz_ff;
      d_den_in[0] = s2_mag_ff[2];
      for (int k = 1; k <= CW; k++) begin
         dsh = REM_W'(d_den_ff[k-1]) << (CW - k);
         for (int c = 0; c < 2; c++) begin
            if (d_rem_ff[k-1][c] >= dsh) begin
               d_rem_in[k][c] = d_rem_ff[k-1][c] - dsh;
               d_q_in[k][c]   = d_q_ff[k-1][c] | (CW'(1) << (CW - k));
            end else begin
               d_rem_in[k][c] = d_rem_ff[k-1][c];
               d_q_in[k][c]   = d_q_ff[k-1][c];
            end
         end
         d_ovf_in[k] = d_ovf_ff[k-1];
         d_neg_in[k] = d_neg_ff[k-1];
         d_wz_in[k]  = d_wz_ff[k-1];
         d_den_in[k] = d_den_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= CW; k++) begin
         if (move[DIV0 + k]) begin
            d_rem_ff[k] <= d_rem_in[k];
            d_q_ff[k]   <= d_q_in[k];
            d_ovf_ff[k] <= d_ovf_in[k];
            d_neg_ff[k] <= d_neg_in[k];
            d_wz_ff[k]  <= d_wz_in[k];
            d_den_ff[k] <= d_den_in[k];
         end
      end
   end

   // clamp, restore sign, zero w forces zero outputs
   always_comb begin
      logic [CW-1:0] lim;
      logic [CW-1:0] qs;
      logic [1:0]    clip;
      for (int c = 0; c < 2; c++) begin
         lim     = d_neg_ff[CW][c] ? SAT_NEG : SAT_POS;
         clip[c] = d_ovf_ff[CW][c] || (d_q_ff[CW][c] > lim);
         qs      = clip[c] ? lim : d_q_ff[CW][c];
         if (d_wz_ff[CW]) begin
            out_in[c] = '0;
         end else begin
            out_in[c] = d_neg_ff[CW][c] ? -qs : qs;
         end
      end
      sat_in = !d_wz_ff[CW] && (|clip);
   end

   always_ff @(posedge clock) begin
      if (move[LAST]) begin
         out_ff <= out_in;
         wz_ff  <= d_wz_ff[CW];
         sat_ff <= sat_in;
      end
   end

   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_w_zero    = wz_ff;
   assign rsp_saturated = sat_ff;

endmodule

@@ sim/tb_homogeneous_point_transform_2d.sv @@
// testbench for homogeneous_point_transform_2d: random and directed points through several
// matrices, each result checked against an in-bench projection of (x, y, 1) * M
// depends on hpt2d_pkg and the rtl of homogeneous_point_transform_2d
`timescale 1ns / 1ps

module tb_homogeneous_point_transform_2d;
   import hpt2d_pkg::*;

   localparam int CW            = COORD_WIDTH_DEF;
   localparam int FB            = FRAC_BITS_DEF;
   localparam int LATENCY       = CW + 5;
   localparam int PHASE_POINTS  = 90;
   localparam int TIMEOUT_NS    = 400_000;
   localparam longint SCALE     = longint'(1) << FB;
   localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
   localparam logic [CW-1:0] ENTRY_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] ENTRY_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] ENTRY_ONE = CW'(SCALE);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
   } point_type;

   typedef struct packed {
      logic signed [CW-1:0] out_x;
      logic signed [CW-1:0] out_y;
      logic                 w_zero;
      logic                 saturated;
   } projected_point_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [CW-1:0]       req_point_x = '0;
   logic signed [CW-1:0]       req_point_y = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [CW-1:0]       rsp_out_x;
   logic signed [CW-1:0]       rsp_out_y;
   logic                       rsp_w_zero;
   logic                       rsp_saturated;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [REG_WIDTH-1:0]       csr_wdata = '0;

   point_type           pending_points[$];
   projected_point_type expected_points[$];
   logic [REG_WIDTH-1:0] matrix_rows[3];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;

   homogeneous_point_transform_2d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_w_zero(rsp_w_zero), .rsp_saturated(rsp_saturated),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [REG_WIDTH-1:0] pack_row(logic [CW-1:0] e0, logic [CW-1:0] e1,
                                                      logic [CW-1:0] e2);
      return {e2, e1, e0};
   endfunction

   function automatic longint matrix_entry(int row, int col);
      logic signed [CW-1:0] e;
      e = matrix_rows[row][col*CW +: CW];
      return e;
   endfunction

   function automatic longint clamp_coord(longint q);
      if (q > COORD_MAX) return COORD_MAX;
      if (q < COORD_MIN) return COORD_MIN;
      return q;
   endfunction

   // (x, y, 1) * M, then X/W and Y/W truncated toward zero and clamped
   function automatic projected_point_type project_point(logic signed [CW-1:0] px,
                                                         logic signed [CW-1:0] py);
      longint x, y, acc_x, acc_y, acc_w, qx, qy;
      projected_point_type r;
      x = px;
      y = py;
      acc_x = x * matrix_entry(0, 0) + y * matrix_entry(1, 0) + SCALE * matrix_entry(2, 0);
      acc_y = x * matrix_entry(0, 1) + y * matrix_entry(1, 1) + SCALE * matrix_entry(2, 1);
      acc_w = x * matrix_entry(0, 2) + y * matrix_entry(1, 2) + SCALE * matrix_entry(2, 2);
      r = '0;
      if (acc_w == 0) begin
         r.w_zero = 1'b1;
      end else begin
         qx = (acc_x * SCALE) / acc_w;
         qy = (acc_y * SCALE) / acc_w;
         r.out_x = CW'(clamp_coord(qx));
         r.out_y = CW'(clamp_coord(qy));
         r.saturated = (clamp_coord(qx) != qx) || (clamp_coord(qy) != qy);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] small_entry(int span);
      logic signed [CW-1:0] v;
      v = CW'($urandom_range(0, span));
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic logic [CW-1:0] random_coord();
      logic [CW-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = ENTRY_MAX;
               1: v = ENTRY_MIN;
               2: v = '0;
               3: v = '1;
               default: v = CW'(1);
            endcase
         end
         1, 2, 3, 4: v = CW'($urandom);
         default: v = small_entry(4096);
      endcase
      return v;
   endfunction

   task automatic queue_point(logic [CW-1:0] px, logic [CW-1:0] py);
      pending_points.push_back({px, py});
   endtask

   task automatic write_matrix_row(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [REG_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index <= CSR_MATRIX_ROW2) matrix_rows[index] = value;
   endtask

   // checked away from the rising edge so the driver and monitor have settled
   task automatic wait_for_drain();
      while (pending_points.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(string field, longint expected_val, longint actual_val);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected_val,
               actual_val);
      error_count++;
   endtask

   // request driver: holds the payload while stalled, otherwise may idle
   always @(posedge clock) begin
      point_type next_point;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_points.push_back(project_point(req_point_x, req_point_y));
         if (!req_valid || !req_stall) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_point = pending_points.pop_front();
               req_valid <= 1'b1;
               req_point_x <= next_point.px;
               req_point_y <= next_point.py;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and random back-pressure
   always @(posedge clock) begin
      projected_point_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $display("%0t: result with nothing expected, out_x %0d out_y %0d", $time,
                        rsp_out_x, rsp_out_y);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_out_x !== want.out_x) report_mismatch("out_x", want.out_x, rsp_out_x);
               if (rsp_out_y !== want.out_y) report_mismatch("out_y", want.out_y, rsp_out_y);
               if (rsp_w_zero !== want.w_zero)
                  report_mismatch("w_zero", want.w_zero, rsp_w_zero);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", want.saturated, rsp_saturated);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      logic [CW-1:0] m22;
      matrix_rows[0] = pack_row(ENTRY_ONE, '0, '0);
      matrix_rows[1] = pack_row('0, ENTRY_ONE, '0);
      matrix_rows[2] = pack_row('0, '0, ENTRY_ONE);
      send_idle_pct = 15;
      recv_idle_pct = 61;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // identity after reset: extremes and alternating bit patterns pass straight through
      queue_point('0, '0);
      queue_point(ENTRY_MAX, ENTRY_MAX);
      queue_point(ENTRY_MIN, ENTRY_MIN);
      queue_point(ENTRY_MAX, ENTRY_MIN);
      queue_point(ENTRY_MIN, ENTRY_MAX);
      queue_point(CW'(1), '1);
      queue_point(20'h55555, 20'haaaaa);
      queue_point(20'haaaaa, 20'h55555);
      wait_for_drain();

      // an index past the last row must be ignored
      write_matrix_row(CSR_INDEX_UNUSED, '1);
      // w = x: zero w at x = 0, out_y = y / x exercises truncation and clamping
      write_matrix_row(CSR_MATRIX_ROW0, pack_row(ENTRY_ONE, '0, ENTRY_ONE));
      write_matrix_row(CSR_MATRIX_ROW1, pack_row('0, ENTRY_ONE, '0));
      write_matrix_row(CSR_MATRIX_ROW2, '0);
      queue_point('0, CW'(100));
      queue_point('0, ENTRY_MIN);
      queue_point(CW'(5), CW'(7));
      queue_point(CW'(-5), CW'(7));
      queue_point(CW'(5), CW'(-7));
      queue_point(CW'(1), ENTRY_MAX);
      queue_point(CW'(1), ENTRY_MIN);
      queue_point('1, ENTRY_MIN);
      queue_point(ENTRY_MAX, CW'(1));
      queue_point(ENTRY_MIN, ENTRY_MIN);
      queue_point(CW'(1), CW'(2048));
      queue_point(CW'(1), CW'(-2048));
      wait_for_drain();

      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 15;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: begin
               write_matrix_row(CSR_MATRIX_ROW0, pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
               write_matrix_row(CSR_MATRIX_ROW1, pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
               write_matrix_row(CSR_MATRIX_ROW2, pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
            end
            1: begin
               write_matrix_row(CSR_MATRIX_ROW0, REG_WIDTH'({$urandom, $urandom}));
               write_matrix_row(CSR_MATRIX_ROW1, REG_WIDTH'({$urandom, $urandom}));
               write_matrix_row(CSR_MATRIX_ROW2, REG_WIDTH'({$urandom, $urandom}));
            end
            3: begin
               write_matrix_row(CSR_MATRIX_ROW0, pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
               write_matrix_row(CSR_MATRIX_ROW1, pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
               write_matrix_row(CSR_MATRIX_ROW2, pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
            end
            5: begin
               // all-zero matrix, every w is zero
               write_matrix_row(CSR_MATRIX_ROW0, '0);
               write_matrix_row(CSR_MATRIX_ROW1, '0);
               write_matrix_row(CSR_MATRIX_ROW2, '0);
            end
            6: begin
               write_matrix_row(CSR_MATRIX_ROW0, '1);
               write_matrix_row(CSR_MATRIX_ROW1, '1);
               write_matrix_row(CSR_MATRIX_ROW2, '1);
            end
            2, 7: begin
               // affine: constant nonzero w
               m22 = small_entry(1024);
               if (m22 == '0) m22 = ENTRY_ONE;
               write_matrix_row(CSR_MATRIX_ROW0,
                                pack_row(small_entry(2048), small_entry(2048), '0));
               write_matrix_row(CSR_MATRIX_ROW1,
                                pack_row(small_entry(2048), small_entry(2048), '0));
               write_matrix_row(CSR_MATRIX_ROW2, pack_row(random_coord(), random_coord(), m22));
            end
            default: begin
               write_matrix_row(CSR_MATRIX_ROW0,
                                pack_row(small_entry(512), small_entry(512), small_entry(512)));
               write_matrix_row(CSR_MATRIX_ROW1,
                                pack_row(small_entry(512), small_entry(512), small_entry(512)));
               write_matrix_row(CSR_MATRIX_ROW2,
                                pack_row(small_entry(512), small_entry(512), small_entry(512)));
            end
         endcase
         for (int n = 0; n < PHASE_POINTS; n++) queue_point(random_coord(), random_coord());
         wait_for_drain();
      end

      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_homogeneous_point_transform_2d: done, clean");
      end else begin
         $display("tb_homogeneous_point_transform_2d: done, errors");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("tb_homogeneous_point_transform_2d: done, errors");
      $finish;
   end

endmodule

@@ files.f @@
rtl/hpt2d_pkg.sv
rtl/homogeneous_point_transform_2d.sv
sim/tb_homogeneous_point_transform_2d.sv
